[hw/rtl/qts_pkg.sv]
// ----------------------------------------------------------------------------
// Query text sanitizer package
// Shared constants and the command format passed from the front to the back.
// ----------------------------------------------------------------------------
package qts_pkg;

	localparam int MAX_DEPTH = 62;
	localparam int DEPTH_W = 6;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = 1;
	localparam int CFG_W = 64;
	localparam int NUM_CFG = 4;
	localparam int ADDR_W = 5;

	localparam logic [7:0] CH_ESC = 8'h5C;
	localparam logic [7:0] CH_OPEN = 8'h28;
	localparam logic [7:0] CH_CLOSE = 8'h29;

	localparam logic [1:0] CMD_EMIT = 2'd0;
	localparam logic [1:0] CMD_PAIR = 2'd1;
	localparam logic [1:0] CMD_FLUSH = 2'd2;

	localparam logic [1:0] REG_OP_SET_0 = 2'd0;
	localparam logic [1:0] REG_OP_SET_1 = 2'd1;
	localparam logic [1:0] REG_OP_SET_2 = 2'd2;
	localparam logic [1:0] REG_OP_SET_3 = 2'd3;

	typedef struct packed {
		logic [1:0]         kind;
		logic [7:0]         ch;
		logic [DEPTH_W-1:0] count;
		logic               ovf;
	} cmd_t;

endpackage

[hw/rtl/qts_if.sv]
// ----------------------------------------------------------------------------
// Query text sanitizer channels
// Valid/ready channels for raw query bytes and for cleaned result beats.
// ----------------------------------------------------------------------------
interface qts_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       end_of_text;

	modport source (output valid, output char_in, output end_of_text, input ready);
	modport sink (input valid, input char_in, input end_of_text, output ready);
endinterface

interface qts_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_out;
	logic       is_end_mark;
	logic       depth_overflow;
	logic       last;

	modport source (output valid, output char_out, output is_end_mark,
		output depth_overflow, output last, input ready);
	modport sink (input valid, input char_out, input is_end_mark,
		input depth_overflow, input last, output ready);
endinterface

[hw/rtl/qts_front.sv]
// ----------------------------------------------------------------------------
// Query text sanitizer front end
// Accepts bytes, classifies them and keeps escape, operator and depth state.
// ----------------------------------------------------------------------------
module qts_front import qts_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	qts_in_if.sink      in_ch,
	input  logic [255:0] op_bits,
	input  logic        full,
	output logic        push,
	output cmd_t        push_cmd
);

	logic               esc_q;
	logic               prev_op_q;
	logic [DEPTH_W-1:0] depth_q;
	logic               ovf_q;

	logic               esc_d;
	logic               prev_op_d;
	logic [DEPTH_W-1:0] depth_d;
	logic               ovf_d;
	logic               keep;
	logic               accept;
	logic [7:0]         b;

	assign in_ch.ready = !full;
	assign accept = in_ch.valid && !full;
	assign b = in_ch.char_in;
	assign push = accept && keep;

	always_comb begin
		esc_d = esc_q;
		prev_op_d = prev_op_q;
		depth_d = depth_q;
		ovf_d = ovf_q;
		keep = 1'b1;
		push_cmd.kind = CMD_EMIT;
		push_cmd.ch = b;
		push_cmd.count = depth_q;
		push_cmd.ovf = ovf_q;
		if (in_ch.end_of_text) begin
			push_cmd.kind = CMD_FLUSH;
			esc_d = 1'b0;
			prev_op_d = 1'b0;
			depth_d = '0;
			ovf_d = 1'b0;
		end else if (esc_q) begin
			push_cmd.kind = CMD_PAIR;
			esc_d = 1'b0;
		end else if (b == CH_ESC) begin
			esc_d = 1'b1;
			keep = 1'b0;
		end else if (b == CH_CLOSE) begin
			if (depth_q != '0) begin
				depth_d = depth_q - DEPTH_W'(1);
			end else begin
				keep = 1'b0;
			end
		end else if (op_bits[b]) begin
			if (!prev_op_q) begin
				prev_op_d = 1'b1;
			end else begin
				keep = 1'b0;
			end
		end else if (b == CH_OPEN) begin
			if (depth_q >= DEPTH_W'(MAX_DEPTH)) begin
				depth_d = DEPTH_W'(MAX_DEPTH);
				ovf_d = 1'b1;
				push_cmd.ovf = 1'b1;
			end else begin
				depth_d = depth_q + DEPTH_W'(1);
			end
		end else begin
			prev_op_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_q <= 1'b0;
			prev_op_q <= 1'b0;
			depth_q <= '0;
			ovf_q <= 1'b0;
		end else if (accept) begin
			esc_q <= esc_d;
			prev_op_q <= prev_op_d;
			depth_q <= depth_d;
			ovf_q <= ovf_d;
		end
	end

endmodule

[hw/rtl/qts_queue.sv]
// ----------------------------------------------------------------------------
// Query text sanitizer command queue
// Two-entry queue that decouples the front end from the beat generator.
// ----------------------------------------------------------------------------
module qts_queue import qts_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	input  logic pop,
	output logic full,
	output logic empty,
	output cmd_t head
);

	cmd_t            mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QPTR_W:0]   count_q;

	assign full = (count_q == (QPTR_W+1)'(QUEUE_DEPTH));
	assign empty = (count_q == '0);
	assign head = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + (QPTR_W+1)'(1);
			end else if (pop && !push) begin
				count_q <= count_q - (QPTR_W+1)'(1);
			end
		end
	end

endmodule

[hw/rtl/qts_back.sv]
// ----------------------------------------------------------------------------
// Query text sanitizer back end
// Turns queued commands into result beats held in an output register.
// ----------------------------------------------------------------------------
module qts_back import qts_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   empty,
	input  cmd_t   head,
	output logic   pop,
	qts_out_if.source out_ch
);

	logic               out_valid_q;
	logic [7:0]         char_q;
	logic               end_q;
	logic               ovf_q;
	logic               last_q;
	logic [DEPTH_W-1:0] step_q;

	logic               load;
	logic [7:0]         beat_char;
	logic               beat_end;
	logic               beat_last;

	assign load = !empty && (!out_valid_q || out_ch.ready);
	assign pop = load && beat_last;

	always_comb begin
		beat_char = head.ch;
		beat_end = 1'b0;
		beat_last = 1'b1;
		case (head.kind)
			CMD_EMIT: begin
				beat_last = 1'b1;
			end
			CMD_PAIR: begin
				if (step_q == '0) begin
					beat_char = CH_ESC;
					beat_last = 1'b0;
				end
			end
			CMD_FLUSH: begin
				if (step_q < head.count) begin
					beat_char = CH_CLOSE;
					beat_last = 1'b0;
				end else begin
					beat_char = '0;
					beat_end = 1'b1;
				end
			end
			default: begin
				beat_last = 1'b1;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			step_q <= '0;
		end else begin
			if (load) begin
				out_valid_q <= 1'b1;
				step_q <= beat_last ? '0 : step_q + DEPTH_W'(1);
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			char_q <= beat_char;
			end_q <= beat_end;
			ovf_q <= head.ovf;
			last_q <= beat_last;
		end
	end

	assign out_ch.valid = out_valid_q;
	assign out_ch.char_out = char_q;
	assign out_ch.is_end_mark = end_q;
	assign out_ch.depth_overflow = ovf_q;
	assign out_ch.last = last_q;

endmodule

[hw/rtl/query_text_sanitizer.sv]
// ----------------------------------------------------------------------------
// Query text sanitizer
// Cleans a search-query byte stream: escapes, stray braces, repeated
// operators, and a closing-brace flush with an end mark at end of query.
// ----------------------------------------------------------------------------
// Raw bytes arrive on in_ch, one per beat; end_of_text marks the end item.
// Cleaned bytes leave on out_ch, with last set on the final beat of each
// input item. The operator set is written over the APB port, one 64-bit
// word per register at byte addresses 0, 8, 16 and 24; the user must write
// it only while the block is idle; the block does not enforce it. Accepted
// bytes are classified, queued and loaded into the output register, one
// beat per cycle unless out_ch stalls. A kept plain byte gives one beat, an
// escaped pair the escape then the byte, an end item a closing brace per
// open brace plus the end mark. The two-entry queue lets input go on during
// a flush or output stall; when full, in_ch.ready drops until the beat
// generator frees an entry. Reset clears the state, queue and operator set.
// ----------------------------------------------------------------------------
module query_text_sanitizer import qts_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	qts_in_if.sink            in_ch,
	qts_out_if.source         out_ch,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [CFG_W-1:0]  pwdata,
	output logic [CFG_W-1:0]  prdata,
	output logic              pready
);

	logic [CFG_W-1:0] op_set_q [NUM_CFG];
	logic [1:0]       reg_idx;
	logic             cfg_wr;
	logic             push;
	logic             pop;
	logic             full;
	logic             empty;
	cmd_t             push_cmd;
	cmd_t             head;
	logic [255:0]     op_bits;

	assign pready = 1'b1;
	assign reg_idx = paddr[4:3];
	assign cfg_wr = psel && penable && pwrite;
	assign prdata = op_set_q[reg_idx];
	assign op_bits = {op_set_q[REG_OP_SET_3], op_set_q[REG_OP_SET_2],
		op_set_q[REG_OP_SET_1], op_set_q[REG_OP_SET_0]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_CFG; i++) begin
				op_set_q[i] <= '0;
			end
		end else if (cfg_wr) begin
			op_set_q[reg_idx] <= pwdata;
		end
	end

	qts_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_ch    (in_ch),
		.op_bits  (op_bits),
		.full     (full),
		.push     (push),
		.push_cmd (push_cmd)
	);

	qts_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.pop      (pop),
		.full     (full),
		.empty    (empty),
		.head     (head)
	);

	qts_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.empty  (empty),
		.head   (head),
		.pop    (pop),
		.out_ch (out_ch)
	);

endmodule

[test/tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Query text sanitizer testbench
// Drives raw query bytes and end items into the sanitizer and checks every
// result beat against a cycle-free prediction of the cleaned stream. The
// operator set is changed between phases while the block is idle. A directed
// sequence is followed by random queries. Both channels stall at random in the earlier phases.
// ----------------------------------------------------------------------------
module tb;
	import qts_pkg::*;

	typedef struct packed {
		logic [7:0] ch;
		logic       eot;
	} query_byte_t;

	typedef struct packed {
		logic [7:0] ch;
		logic       end_mark;
		logic       ovf;
		logic       last;
	} result_beat_t;

	localparam logic [7:0] OP_CHARS [9] = '{8'h21, 8'h26, 8'h29, 8'h2D, 8'h5C,
		8'h7C, 8'h7E, 8'h80, 8'hFF};
	localparam logic [1:0] OP_SET_REGS [NUM_CFG] = '{REG_OP_SET_0, REG_OP_SET_1,
		REG_OP_SET_2, REG_OP_SET_3};

	logic              clk = 1'b0;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [CFG_W-1:0]  pwdata;
	logic [CFG_W-1:0]  prdata;
	logic              pready;

	qts_in_if  in_ch ();
	qts_out_if out_ch ();

	query_text_sanitizer u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_ch   (in_ch),
		.out_ch  (out_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	query_byte_t  raw_bytes[$];
	result_beat_t expected_beats[$];
	query_byte_t  next_byte;
	int           queued_items = 0;
	int           n_fail = 0;
	int           src_idle_pct = 0;
	int           snk_idle_pct = 0;

	logic [255:0] operator_bits = '0;
	logic         esc_armed = 1'b0;
	logic         op_open = 1'b0;
	int           brace_depth = 0;
	logic         ovf_seen = 1'b0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic void add_beat(input logic [7:0] ch, input logic end_mark,
		input logic last);
		result_beat_t r;
		r.ch = ch;
		r.end_mark = end_mark;
		r.ovf = ovf_seen;
		r.last = last;
		expected_beats = {expected_beats, r};
	endfunction

	task automatic clean_byte(input logic [7:0] b, input logic eot);
		if (eot) begin
			for (int i = 0; i < brace_depth; i++)
				add_beat(CH_CLOSE, 1'b0, 1'b0);
			add_beat(8'h00, 1'b1, 1'b1);
			esc_armed = 1'b0;
			op_open = 1'b0;
			brace_depth = 0;
			ovf_seen = 1'b0;
		end else if (esc_armed) begin
			esc_armed = 1'b0;
			add_beat(CH_ESC, 1'b0, 1'b0);
			add_beat(b, 1'b0, 1'b1);
		end else if (b == CH_ESC) begin
			esc_armed = 1'b1;
		end else if (b == CH_CLOSE) begin
			if (brace_depth != 0) begin
				brace_depth--;
				add_beat(b, 1'b0, 1'b1);
			end
		end else if (operator_bits[b]) begin
			if (!op_open) begin
				op_open = 1'b1;
				add_beat(b, 1'b0, 1'b1);
			end
		end else if (b == CH_OPEN) begin
			if (brace_depth >= MAX_DEPTH)
				ovf_seen = 1'b1;
			else
				brace_depth++;
			add_beat(b, 1'b0, 1'b1);
		end else begin
			op_open = 1'b0;
			add_beat(b, 1'b0, 1'b1);
		end
	endtask

	task automatic check_field(input string name, input logic [7:0] want,
		input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			n_fail++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_ch.valid && in_ch.ready)
				clean_byte(in_ch.char_in, in_ch.end_of_text);
			if (!in_ch.valid || in_ch.ready) begin
				if (raw_bytes.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
					next_byte = raw_bytes.pop_front();
					in_ch.valid <= 1'b1;
					in_ch.char_in <= next_byte.ch;
					in_ch.end_of_text <= next_byte.eot;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : result_monitor
		result_beat_t want;
		if (arst_n) begin
			if (out_ch.valid && out_ch.ready) begin
				if (expected_beats.size() == 0) begin
					$error("unexpected result beat: char_out %0h", out_ch.char_out);
					n_fail++;
				end else begin
					want = expected_beats.pop_front();
					check_field("char_out", want.ch, out_ch.char_out);
					check_field("is_end_mark", {7'b0, want.end_mark},
						{7'b0, out_ch.is_end_mark});
					check_field("depth_overflow", {7'b0, want.ovf},
						{7'b0, out_ch.depth_overflow});
					check_field("last", {7'b0, want.last}, {7'b0, out_ch.last});
				end
			end
			out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
		end
	end

	task automatic queue_byte(input logic [7:0] ch, input logic eot);
		query_byte_t q;
		q.ch = ch;
		q.eot = eot;
		raw_bytes = {raw_bytes, q};
		queued_items++;
	endtask

	function automatic logic [7:0] pick_byte();
		case ($urandom_range(9))
			0, 1, 2: return 8'($urandom_range(8'h7A, 8'h61));
			3, 4: return OP_CHARS[$urandom_range(8)];
			5: return CH_OPEN;
			6: return CH_CLOSE;
			7: return CH_ESC;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic queue_query(input bit deep);
		int n;
		if (deep) begin
			n = $urandom_range(MAX_DEPTH + 4, MAX_DEPTH - 6);
			for (int i = 0; i < n; i++)
				queue_byte(($urandom_range(7) == 0) ? pick_byte() : CH_OPEN, 1'b0);
		end else begin
			n = $urandom_range(24);
			for (int i = 0; i < n; i++)
				queue_byte(pick_byte(), 1'b0);
		end
		queue_byte(8'($urandom_range(255)), 1'b1);
	endtask

	task automatic wait_drained();
		do
			@(negedge clk);
		while (raw_bytes.size() != 0 || in_ch.valid || expected_beats.size() != 0);
		repeat (8) @(negedge clk);
	endtask

	task automatic program_op_set(input logic [255:0] ops);
		for (int k = 0; k < NUM_CFG; k++) begin
			@(posedge clk);
			psel <= 1'b1;
			penable <= 1'b0;
			pwrite <= 1'b1;
			paddr <= {OP_SET_REGS[k], 3'b000};
			pwdata <= ops[64*k +: 64];
			@(posedge clk);
			penable <= 1'b1;
			@(posedge clk);
			psel <= 1'b0;
			penable <= 1'b0;
			pwrite <= 1'b0;
			@(posedge clk);
			psel <= 1'b1;
			@(posedge clk);
			penable <= 1'b1;
			@(posedge clk);
			if (prdata !== ops[64*k +: 64]) begin
				$error("prdata: expected %0h, got %0h", ops[64*k +: 64], prdata);
				n_fail++;
			end
			psel <= 1'b0;
			penable <= 1'b0;
		end
		@(negedge clk);
		operator_bits = ops;
	endtask

	task automatic run_random(input int n_items);
		int start;
		start = queued_items;
		queue_query(1'b1);
		while (queued_items - start < n_items)
			queue_query(1'b0);
		wait_drained();
	endtask

	initial begin
		logic [255:0] typical_ops;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_ch.valid = 1'b0;
		in_ch.char_in = '0;
		in_ch.end_of_text = 1'b0;
		out_ch.ready = 1'b0;
		typical_ops = '0;
		foreach (OP_CHARS[i])
			typical_ops[OP_CHARS[i]] = 1'b1;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		src_idle_pct = 28;
		snk_idle_pct = 80;
		program_op_set(typical_ops);
		queue_byte("a", 1'b0);
		queue_byte("&", 1'b0);
		queue_byte("|", 1'b0);
		queue_byte(CH_OPEN, 1'b0);
		queue_byte("!", 1'b0);
		queue_byte("b", 1'b0);
		queue_byte(8'hFF, 1'b0);
		queue_byte(CH_CLOSE, 1'b0);
		queue_byte(CH_CLOSE, 1'b0);
		queue_byte(CH_ESC, 1'b0);
		queue_byte("&", 1'b0);
		queue_byte(CH_ESC, 1'b0);
		queue_byte(CH_ESC, 1'b0);
		queue_byte(CH_ESC, 1'b0);
		queue_byte(CH_CLOSE, 1'b0);
		queue_byte(8'h00, 1'b0);
		queue_byte(CH_OPEN, 1'b0);
		queue_byte(CH_OPEN, 1'b0);
		queue_byte(CH_ESC, 1'b0);
		queue_byte(8'hFF, 1'b1);
		queue_byte(8'h00, 1'b1);
		wait_drained();

		program_op_set({256{1'b1}});
		run_random(65);

		src_idle_pct = 80;
		snk_idle_pct = 28;
		program_op_set({$urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
			$urandom, $urandom});
		run_random(65);
		program_op_set('0);
		run_random(65);

		src_idle_pct = 0;
		snk_idle_pct = 0;
		program_op_set(typical_ops);
		run_random(65);
		program_op_set({$urandom & $urandom, $urandom & $urandom, $urandom & $urandom,
			$urandom & $urandom, $urandom & $urandom, $urandom & $urandom,
			$urandom & $urandom, $urandom & $urandom});
		run_random(65);
		program_op_set(typical_ops | {128'h0, {128{1'b1}}});
		run_random(65);

		if (n_fail == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin
		#50_000_000;
		$display("status: fail");
		$finish;
	end

endmodule
